>>> rtl/lfu_replacement_policy_defines.svh
// ----------------------------------------------------------------------------
// lfu replacement policy assertion macros
// shared assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef LFU_REPLACEMENT_POLICY_DEFINES_SVH
`define LFU_REPLACEMENT_POLICY_DEFINES_SVH

// implication checked every cycle outside reset
`define LFU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// sizes, codes and types shared by the lfu replacement policy
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int Entries   = 64;
   localparam int Levels    = 10;
   localparam int TagBits   = 64;
   localparam int IdxBits   = $clog2(Entries);
   localparam int CntBits   = $clog2(Entries + 1);
   localparam int LvlBits   = $clog2(Levels);
   localparam int StampBits = 32;
   localparam int RowBits   = TagBits + LvlBits + StampBits;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_HIT    = 2'd1,
      OP_ERASE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_MISSING = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EVICT,
      S_WRITE,
      S_RESP
   } state_type;

endpackage

>>> rtl/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// single port ram, one write plus one registered read per cycle
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

>>> rtl/lfu_replacement_policy.sv
// ----------------------------------------------------------------------------
// lfu_replacement_policy
// least-frequently-used tag table with fifo tie break, one slot ram scanned
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// req     | in  | tuser opcode[1:0], tdata key_tag[63:0]
// rsp     | out | tuser status,stored,evicted; tdata victim_tag, occupancy
// csr     | in  | data capacity_limit[6:0]
//
// the scan reads one ram row a cycle for match, victim and free slot search;
// a write state follows, preceded by an evict state when an insert evicts,
// and the rsp beat is then offered from the response state.
// the next req beat can be taken in the cycle after the rsp beat.
// reset clears valid bits, live count and stamp counter at once.
// a waiting response holds the block; req is taken only when idle.
// ----------------------------------------------------------------------------
`include "lfu_replacement_policy_defines.svh"

module lfu_replacement_policy (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key_tag[63:0]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // victim_tag[63:0], occupancy[70:64], zero
   output logic [3:0]  rsp_tuser,   // status[1:0], stored[2], evicted[3]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int IB = lfu_pkg::IdxBits;
   localparam int CB = lfu_pkg::CntBits;
   localparam int LB = lfu_pkg::LvlBits;
   localparam int SB = lfu_pkg::StampBits;
   localparam int TB = lfu_pkg::TagBits;

   lfu_pkg::state_type state_ff, state_in;
   logic [lfu_pkg::Entries-1:0] valid_ff, valid_in;
   logic [SB-1:0] stamp_ff, stamp_in;
   logic [CB-1:0] live_ff, live_in;
   logic [6:0]    cap_ff, cap_in;
   lfu_pkg::op_type op_ff, op_in;
   logic [TB-1:0] key_ff, key_in;
   logic [IB:0]   scan_ff, scan_in;      // address counter, holds Entries
   logic          rd_ff, rd_in;          // ram data valid this cycle
   logic [IB-1:0] rdi_ff, rdi_in;        // index of row in ram data
   logic          hit_ff, hit_in;
   logic [IB-1:0] hidx_ff, hidx_in;
   logic [LB-1:0] hlvl_ff, hlvl_in;
   logic          vic_ff, vic_in;
   logic [IB-1:0] vidx_ff, vidx_in;
   logic [LB-1:0] vlvl_ff, vlvl_in;
   logic [SB-1:0] vstp_ff, vstp_in;
   logic [TB-1:0] vtag_ff, vtag_in;
   logic          free_ff, free_in;
   logic [IB-1:0] fidx_ff, fidx_in;
   logic [1:0]    st_ff, st_in;
   logic          sto_ff, sto_in;
   logic          evi_ff, evi_in;

   logic          we;
   logic [IB-1:0] addr;
   logic [lfu_pkg::RowBits-1:0] wdata, rdata;
   logic [TB-1:0] r_tag;
   logic [LB-1:0] r_lvl;
   logic [SB-1:0] r_stp;
   logic [CB-1:0] eff_cap;

   assign r_tag = rdata[TB-1:0];
   assign r_lvl = rdata[TB+LB-1:TB];
   assign r_stp = rdata[lfu_pkg::RowBits-1:TB+LB];

   lfu_ram #(.WIDTH(lfu_pkg::RowBits), .DEPTH(lfu_pkg::Entries)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   always_comb begin
      if (cap_ff == 7'd0) begin
         eff_cap = CB'(1);
      end else if (32'(cap_ff) > lfu_pkg::Entries) begin
         eff_cap = CB'(lfu_pkg::Entries);
      end else begin
         eff_cap = CB'(cap_ff);
      end
   end

   assign req_tready = (state_ff == lfu_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == lfu_pkg::S_RESP);
   assign rsp_tdata  = {1'b0, 7'(live_ff), vtag_ff};
   assign rsp_tuser  = {evi_ff, sto_ff, st_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::S_IDLE;
         valid_ff <= '0;
         stamp_ff <= '0;
         live_ff  <= '0;
         cap_ff   <= 7'd64;
         rd_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         stamp_ff <= stamp_in;
         live_ff  <= live_in;
         cap_ff   <= cap_in;
         rd_ff    <= rd_in;
      end
      op_ff <= op_in;     key_ff <= key_in;   scan_ff <= scan_in;
      rdi_ff <= rdi_in;   hit_ff <= hit_in;   hidx_ff <= hidx_in;
      hlvl_ff <= hlvl_in; vic_ff <= vic_in;   vidx_ff <= vidx_in;
      vlvl_ff <= vlvl_in; vstp_ff <= vstp_in; vtag_ff <= vtag_in;
      free_ff <= free_in; fidx_ff <= fidx_in; st_ff <= st_in;
      sto_ff <= sto_in;   evi_ff <= evi_in;
   end

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; stamp_in = stamp_ff;
      live_in = live_ff;   cap_in = cap_ff;     op_in = op_ff;
      key_in = key_ff;     scan_in = scan_ff;   rd_in = 1'b0;
      rdi_in = rdi_ff;     hit_in = hit_ff;     hidx_in = hidx_ff;
      hlvl_in = hlvl_ff;   vic_in = vic_ff;     vidx_in = vidx_ff;
      vlvl_in = vlvl_ff;   vstp_in = vstp_ff;   vtag_in = vtag_ff;
      free_in = free_ff;   fidx_in = fidx_ff;   st_in = st_ff;
      sto_in = sto_ff;     evi_in = evi_ff;
      we = 1'b0;
      addr = scan_ff[IB-1:0];
      wdata = '0;
      if (csr_valid) begin
         cap_in = csr_data;
      end
      case (state_ff)
         lfu_pkg::S_IDLE: begin
            if (req_tvalid) begin
               op_in = lfu_pkg::op_type'(req_tuser);
               key_in = req_tdata[TB-1:0];
               scan_in = '0;
               hit_in = 1'b0; vic_in = 1'b0; free_in = 1'b0;
               vtag_in = '0; st_in = lfu_pkg::ST_OK;
               sto_in = 1'b0; evi_in = 1'b0;
               state_in = lfu_pkg::S_SCAN;
            end
         end
         lfu_pkg::S_SCAN: begin
            // issue one read per cycle, evaluate last cycle's row
            if (!scan_ff[IB]) begin
               rd_in = 1'b1;
               rdi_in = scan_ff[IB-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (rd_ff) begin
               if (valid_ff[rdi_ff]) begin
                  if (r_tag == key_ff && !hit_ff) begin
                     hit_in = 1'b1; hidx_in = rdi_ff; hlvl_in = r_lvl;
                  end
                  if (!vic_ff || r_lvl < vlvl_ff
                      || (r_lvl == vlvl_ff && r_stp < vstp_ff)) begin
                     vic_in = 1'b1; vidx_in = rdi_ff;
                     vlvl_in = r_lvl; vstp_in = r_stp; vtag_in = r_tag;
                  end
               end else if (!free_ff) begin
                  free_in = 1'b1; fidx_in = rdi_ff;
               end
            end
            if (scan_ff[IB] && !rd_ff) begin
               state_in = lfu_pkg::S_WRITE;
               if (op_ff == lfu_pkg::OP_INSERT && !hit_ff && live_ff >= eff_cap
                   && vic_ff) begin
                  state_in = lfu_pkg::S_EVICT;
               end
            end
         end
         lfu_pkg::S_EVICT: begin
            // victim slot becomes the lowest free one if below the found free
            valid_in[vidx_ff] = 1'b0;
            live_in = live_ff - 1'b1;
            evi_in = 1'b1;
            if (!free_ff || vidx_ff < fidx_ff) begin
               fidx_in = vidx_ff;
            end
            free_in = 1'b1;
            state_in = lfu_pkg::S_WRITE;
         end
         lfu_pkg::S_WRITE: begin
            state_in = lfu_pkg::S_RESP;
            if (!evi_ff) begin
               vtag_in = '0;
            end
            case (op_ff)
               lfu_pkg::OP_INSERT: begin
                  if (hit_ff) begin
                     st_in = lfu_pkg::ST_DUP;
                  end else if (free_ff) begin
                     we = 1'b1; addr = fidx_ff;
                     wdata = {stamp_ff, LB'(0), key_ff};
                     valid_in[fidx_ff] = 1'b1;
                     live_in = live_ff + 1'b1;
                     stamp_in = stamp_ff + 1'b1;
                     sto_in = 1'b1;
                  end
               end
               lfu_pkg::OP_HIT: begin
                  if (!hit_ff) begin
                     st_in = lfu_pkg::ST_MISSING;
                  end else if (32'(hlvl_ff) < lfu_pkg::Levels - 1) begin
                     we = 1'b1; addr = hidx_ff;
                     wdata = {stamp_ff, hlvl_ff + 1'b1, key_ff};
                     stamp_in = stamp_ff + 1'b1;
                  end
               end
               lfu_pkg::OP_ERASE: begin
                  if (!hit_ff) begin
                     st_in = lfu_pkg::ST_MISSING;
                  end else begin
                     valid_in[hidx_ff] = 1'b0;
                     live_in = live_ff - 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         lfu_pkg::S_RESP: begin
            if (rsp_tready) begin
               state_in = lfu_pkg::S_IDLE;
            end
         end
         default: state_in = lfu_pkg::S_IDLE;
      endcase
   end

   `LFU_ASSERT_IMPL(a_live_count, clock, reset, 1'b1, 32'($countones(valid_ff)) == 32'(live_ff))
   `LFU_ASSERT_IMPL(a_evict_store, clock, reset, rsp_tvalid && rsp_tuser[3], rsp_tuser[2])
   `LFU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `LFU_ASSERT_IMPL(a_no_ready_busy, clock, reset, rsp_tvalid, !req_tready)

endmodule
